>>> design/mrcc_pkg.sv
// ----------------------------------------------------------------------------
// mrcc_pkg
// shared codes, widths and helpers of the mixed radix calendar converter
// ----------------------------------------------------------------------------
package mrcc_pkg;

  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int RADIX_W        = 9;
  localparam int NUM_LEVELS     = 5;
  localparam int BITS_PER_STAGE = 4;

  typedef enum logic [1:0] {
    CMD_SPLIT   = 2'd0,
    CMD_COMPOSE = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_EPOCH_YEAR        = 3'd0,
    REG_SECONDS_PER_MIN   = 3'd1,
    REG_MINUTES_PER_HOUR  = 3'd2,
    REG_HOURS_PER_DAY     = 3'd3,
    REG_DAYS_PER_WEEK     = 3'd4,
    REG_WEEKS_PER_MONTH   = 3'd5,
    REG_MONTHS_PER_SEASON = 3'd6,
    REG_SEASONS_PER_YEAR  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [RADIX_W-1:0] spm;
    logic [RADIX_W-1:0] mph;
    logic [RADIX_W-1:0] hpd;
    logic [RADIX_W-1:0] dpm;
    logic [RADIX_W-1:0] mpy;
  } radix_t;

  function automatic logic [7:0] clamp_radix(input logic [7:0] v, input logic [7:0] hi);
    logic [7:0] res;
    if (v == 8'd0) begin
      res = 8'd1;
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

>>> design/mixed_radix_calendar_converter.sv
// ----------------------------------------------------------------------------
// mixed_radix_calendar_converter
// splits, composes and advances calendar dates with configurable radices
// ----------------------------------------------------------------------------
// channel   direction  handshake                   payload
// cfg       in         cfg_we_i (no wait)          cfg_idx_i, cfg_data_i
// in        in         in_valid_i / in_ready_o     command_i .. advance_seconds_i
// out       out        out_valid_o / out_ready_i   total_seconds_out_o .. flags
//
// one transaction per cycle while the output is not stalled; five chained radix
// dividers retire four quotient bits per stage
// reset clears the valid bits and loads the default calendar radices
// a stall at the output freezes every stage together; nothing is lost or repeated
// ----------------------------------------------------------------------------
module mixed_radix_calendar_converter
  import mrcc_pkg::*;
#(
  parameter int SECONDS_WIDTH = 32,
  parameter int YEAR_WIDTH    = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               command_i,
  input  logic [SECONDS_WIDTH-1:0] total_seconds_i,
  input  logic [YEAR_WIDTH-1:0]    year_in_i,
  input  logic [7:0]               month_in_i,
  input  logic [6:0]               day_in_i,
  input  logic [7:0]               hour_in_i,
  input  logic [7:0]               minute_in_i,
  input  logic [7:0]               second_in_i,
  input  logic [15:0]              advance_seconds_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [SECONDS_WIDTH-1:0] total_seconds_out_o,
  output logic [YEAR_WIDTH-1:0]    year_out_o,
  output logic [7:0]               month_out_o,
  output logic [6:0]               day_out_o,
  output logic [7:0]               hour_out_o,
  output logic [7:0]               minute_out_o,
  output logic [7:0]               second_out_o,
  output logic                     before_epoch_o,
  output logic                     total_overflow_o
);

  localparam int SW  = SECONDS_WIDTH;
  localparam int YW  = YEAR_WIDTH;
  localparam int DW  = (SW > 17) ? SW : 18;
  localparam int NS  = (DW + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int NST = NUM_LEVELS * NS + 1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [DW-1:0]      num;
    logic [RADIX_W-1:0] rem;
    logic [SW-1:0]      ts;
    logic [YW-1:0]      yr;
    logic [7:0]         mo;
    logic [6:0]         dy;
    logic [7:0]         hr;
    logic [7:0]         mi;
    logic [7:0]         se;
    logic [15:0]        adv;
    logic               act;
    logic [SW-1:0]      acc;
    logic               ok;
    logic               be;
  } item_t;

  // configuration registers
  logic [15:0] epoch_q;
  logic [7:0]  spm_q, mph_q, hpd_q;
  logic [4:0]  dpw_q;
  logic [3:0]  wpm_q;
  logic [4:0]  mps_q, spy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= 16'd0;
      spm_q   <= 8'd60;
      mph_q   <= 8'd60;
      hpd_q   <= 8'd24;
      dpw_q   <= 5'd7;
      wpm_q   <= 4'd4;
      mps_q   <= 5'd3;
      spy_q   <= 5'd4;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_EPOCH_YEAR:        epoch_q <= cfg_data_i;
        REG_SECONDS_PER_MIN:   spm_q   <= cfg_data_i[7:0];
        REG_MINUTES_PER_HOUR:  mph_q   <= cfg_data_i[7:0];
        REG_HOURS_PER_DAY:     hpd_q   <= cfg_data_i[7:0];
        REG_DAYS_PER_WEEK:     dpw_q   <= cfg_data_i[4:0];
        REG_WEEKS_PER_MONTH:   wpm_q   <= cfg_data_i[3:0];
        REG_MONTHS_PER_SEASON: mps_q   <= cfg_data_i[4:0];
        REG_SEASONS_PER_YEAR:  spy_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  radix_t        rad;
  logic [YW-1:0] ep;
  logic [7:0]    dpw_c, wpm_c, mps_c, spy_c;

  always_comb begin
    dpw_c   = clamp_radix({3'd0, dpw_q}, 8'd16);
    wpm_c   = clamp_radix({4'd0, wpm_q}, 8'd8);
    mps_c   = clamp_radix({3'd0, mps_q}, 8'd16);
    spy_c   = clamp_radix({3'd0, spy_q}, 8'd16);
    rad.spm = {1'b0, clamp_radix(spm_q, 8'd255)};
    rad.mph = {1'b0, clamp_radix(mph_q, 8'd255)};
    rad.hpd = {1'b0, clamp_radix(hpd_q, 8'd255)};
    rad.dpm = RADIX_W'(dpw_c[4:0]) * RADIX_W'(wpm_c[3:0]);
    rad.mpy = RADIX_W'(mps_c[4:0]) * RADIX_W'(spy_c[4:0]);
    ep      = YW'(epoch_q);
  end

  // pipeline
  logic        en;
  logic        vld_q [0:NST];
  item_t       pipe_q [0:NST];
  item_t       in_d;
  logic [YW:0] diff;
  logic [YW+SW-1:0] diff_ext;

  assign en         = !vld_q[NST] || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    diff     = {1'b0, year_in_i} - {1'b0, ep};
    diff_ext = {{SW{1'b0}}, diff[YW-1:0]};
    in_d.cmd = command_i;
    in_d.num = '0;
    in_d.rem = '0;
    in_d.ts  = total_seconds_i;
    in_d.yr  = year_in_i;
    in_d.mo  = month_in_i;
    in_d.dy  = day_in_i;
    in_d.hr  = hour_in_i;
    in_d.mi  = minute_in_i;
    in_d.se  = second_in_i;
    in_d.adv = advance_seconds_i;
    in_d.act = 1'b1;
    in_d.be  = diff[YW];
    if (diff[YW]) begin
      in_d.acc = '0;
      in_d.ok  = 1'b1;
    end else if (diff_ext <= {{YW{1'b0}}, {SW{1'b1}}}) begin
      in_d.acc = diff_ext[SW-1:0];
      in_d.ok  = 1'b1;
    end else begin
      in_d.acc = '1;
      in_d.ok  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NST; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i <= NST; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) pipe_q[0] <= in_d;
  end

  for (genvar k = 1; k <= NST; k++) begin : g_stage
    localparam int L = (k - 1) / NS;
    localparam int J = (k - 1) % NS;

    item_t                nx;
    logic [DW-1:0]        q;
    logic [7:0]           r;
    logic                 wr;
    logic [DW-1:0]        fld;
    logic [RADIX_W-1:0]   dv;
    logic [RADIX_W-1:0]   mul;
    logic [7:0]           add;
    logic [SW+RADIX_W:0]  prod;
    logic [RADIX_W:0]     tmp;

    always_comb begin
      nx   = pipe_q[k-1];
      q    = nx.num;
      r    = nx.rem[7:0];
      fld  = '0;
      mul  = '0;
      add  = '0;
      prod = '0;
      tmp  = '0;
      case (L)
        0:       dv = rad.spm;
        1:       dv = rad.mph;
        2:       dv = rad.hpd;
        3:       dv = rad.dpm;
        default: dv = rad.mpy;
      endcase
      if (J == 0) begin
        // store the remainder of the level just finished
        wr = (nx.cmd == CMD_SPLIT) || ((nx.cmd == CMD_ADVANCE) && nx.act);
        if (wr) begin
          case (L)
            1:       nx.se = r;
            2:       nx.mi = r;
            3:       nx.hr = r;
            4:       nx.dy = r[6:0];
            5:       nx.mo = r;
            default: ;
          endcase
        end
        // load the dividend of the next level
        if (L == 0) begin
          nx.act = 1'b1;
          if (nx.cmd == CMD_ADVANCE) begin
            nx.num = DW'(nx.se) + DW'(nx.adv);
          end else begin
            nx.num = DW'(nx.ts);
          end
        end else begin
          nx.act = nx.act && (q != '0);
          case (L)
            1:       fld = DW'(nx.mi);
            2:       fld = DW'(nx.hr);
            3:       fld = DW'(nx.dy);
            4:       fld = DW'(nx.mo);
            default: fld = '0;
          endcase
          nx.num = (nx.cmd == CMD_ADVANCE) ? fld + q : q;
        end
        nx.rem = '0;
        // compose multiply-accumulate
        if (L < NUM_LEVELS) begin
          case (L)
            0: begin
              mul = rad.mpy;
              add = nx.mo;
            end
            1: begin
              mul = rad.dpm;
              add = {1'b0, nx.dy};
            end
            2: begin
              mul = rad.hpd;
              add = nx.hr;
            end
            3: begin
              mul = rad.mph;
              add = nx.mi;
            end
            default: begin
              mul = rad.spm;
              add = nx.se;
            end
          endcase
          prod = (SW+RADIX_W+1)'(nx.acc) * (SW+RADIX_W+1)'(mul) + (SW+RADIX_W+1)'(add);
          if ((nx.cmd == CMD_COMPOSE) && nx.ok && !nx.be) begin
            if (prod > (SW+RADIX_W+1)'({SW{1'b1}})) begin
              nx.acc = '1;
              nx.ok  = 1'b0;
            end else begin
              nx.acc = prod[SW-1:0];
            end
          end
        end else begin
          // output shaping
          case (cmd_e'(nx.cmd))
            CMD_SPLIT: begin
              nx.yr  = YW'(q) + ep;
              nx.acc = '0;
              nx.ok  = 1'b1;
              nx.be  = 1'b0;
            end
            CMD_ADVANCE: begin
              if (nx.act) nx.yr = nx.yr + YW'(q);
              nx.acc = '0;
              nx.ok  = 1'b1;
              nx.be  = 1'b0;
            end
            CMD_COMPOSE: begin
              nx.yr = '0;
              nx.mo = '0;
              nx.dy = '0;
              nx.hr = '0;
              nx.mi = '0;
              nx.se = '0;
            end
            default: begin
              nx.yr  = '0;
              nx.mo  = '0;
              nx.dy  = '0;
              nx.hr  = '0;
              nx.mi  = '0;
              nx.se  = '0;
              nx.acc = '0;
              nx.ok  = 1'b1;
              nx.be  = 1'b0;
            end
          endcase
        end
      end else begin
        wr = 1'b0;
      end
      // restoring division, four quotient bits per stage
      if (k < NST) begin
        for (int b = 0; b < BITS_PER_STAGE; b++) begin
          if (J * BITS_PER_STAGE + b < DW) begin
            tmp    = {nx.rem, nx.num[DW-1]};
            nx.num = {nx.num[DW-2:0], 1'b0};
            if (tmp >= {1'b0, dv}) begin
              tmp       = tmp - {1'b0, dv};
              nx.num[0] = 1'b1;
            end
            nx.rem = tmp[RADIX_W-1:0];
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) pipe_q[k] <= nx;
    end
  end

  assign out_valid_o         = vld_q[NST];
  assign total_seconds_out_o = pipe_q[NST].acc;
  assign year_out_o          = pipe_q[NST].yr;
  assign month_out_o         = pipe_q[NST].mo;
  assign day_out_o           = pipe_q[NST].dy;
  assign hour_out_o          = pipe_q[NST].hr;
  assign minute_out_o        = pipe_q[NST].mi;
  assign second_out_o        = pipe_q[NST].se;
  assign before_epoch_o      = pipe_q[NST].be;
  assign total_overflow_o    = !pipe_q[NST].ok;

endmodule

>>> design/mrcc_checker.sv
// ----------------------------------------------------------------------------
// mrcc_checker
// port level checks of the mixed radix calendar converter
// ----------------------------------------------------------------------------
module mrcc_checker #(
  parameter int SECONDS_WIDTH = 32
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [SECONDS_WIDTH-1:0] total_seconds_out_o,
  input logic                     before_epoch_o,
  input logic                     total_overflow_o
);

  // stalled transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  a_epoch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && before_epoch_o |-> total_seconds_out_o == '0 && !total_overflow_o)
    else $error("before epoch result not zero");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && total_overflow_o |-> (&total_seconds_out_o))
    else $error("overflow without saturation");

endmodule

bind mixed_radix_calendar_converter mrcc_checker #(
  .SECONDS_WIDTH(SECONDS_WIDTH)
) u_mrcc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_ready_o          (in_ready_o),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .total_seconds_out_o (total_seconds_out_o),
  .before_epoch_o      (before_epoch_o),
  .total_overflow_o    (total_overflow_o)
);
